[rtl/ptwr_pkg.sv]
// ----------------------------------------------------------------------------
// ptwr_pkg
// Shared widths, defaults and controller/datapath interface types for the
// priority tier weighted random pick unit.
// ----------------------------------------------------------------------------
package ptwr_pkg;

   localparam int PRIO_W             = 32;
   localparam int WEIGHT_W           = 20;
   localparam int WORD_W             = 32;
   localparam int INDEX_W            = 6;
   localparam int DIV_CNT_W          = $clog2(WORD_W);
   localparam int REQ_DATA_W         = 88;
   localparam int RSP_DATA_W         = 40;
   localparam int MAX_CANDIDATES_DEF = 64;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;       // request accepted this cycle
      logic div_step;   // one restoring division step
      logic div_last;   // final division step, roll and walk index set up
      logic test;       // compare the fetched candidate against the roll
      logic publish;    // move the result into the response register
   } ptwr_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic list_empty; // no candidate stored once this request is loaded
      logic walk_done;  // roll fits or the last stored candidate was tested
   } ptwr_status_type;

endpackage

[rtl/ptwr_ctrl.sv]
// ----------------------------------------------------------------------------
// ptwr_ctrl
// Sequencer: loading, bit-serial modulo, candidate walk and response hand-off.
// ----------------------------------------------------------------------------
module ptwr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  ptwr_pkg::ptwr_status_type status,
   output ptwr_pkg::ptwr_cmd_type    cmd
);
   import ptwr_pkg::*;

   typedef enum logic [4:0] {
      S_LOAD  = 5'b00001,
      S_DIV   = 5'b00010,
      S_FETCH = 5'b00100,
      S_TEST  = 5'b01000,
      S_SEND  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      cmd          = '0;
      cmd.load     = req_tvalid && (state_ff == S_LOAD);
      unique case (state_ff)
         S_LOAD: begin
            if (cmd.load && req_tlast) begin
               state_in = status.list_empty ? S_SEND : S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (bit_cnt_ff == DIV_CNT_W'(WORD_W - 1)) begin
               cmd.div_last = 1'b1;
               bit_cnt_in   = '0;
               state_in     = S_FETCH;
            end else begin
               bit_cnt_in = bit_cnt_ff + DIV_CNT_W'(1);
            end
         end
         S_FETCH: begin
            state_in = S_TEST;
         end
         S_TEST: begin
            cmd.test = 1'b1;
            state_in = status.walk_done ? S_SEND : S_FETCH;
         end
         S_SEND: begin
            // wait until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.test, cmd.publish}))
      else $error("controller issued overlapping commands");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not presented");

   a_bit_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DIV) |-> (bit_cnt_ff == '0))
      else $error("division counter running outside division");
`endif

endmodule

[rtl/ptwr_dp.sv]
// ----------------------------------------------------------------------------
// ptwr_dp
// Candidate stores, tier tracking, restoring modulo unit, walk and result
// register.
// ----------------------------------------------------------------------------
module ptwr_dp #(
   parameter int MAX_CANDIDATES = ptwr_pkg::MAX_CANDIDATES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptwr_pkg::ptwr_cmd_type        cmd,
   output ptwr_pkg::ptwr_status_type     status,
   input  logic                          req_is_candidate,
   input  logic signed [ptwr_pkg::PRIO_W-1:0]   req_priority,
   input  logic [ptwr_pkg::WEIGHT_W-1:0] req_weight,
   input  logic [ptwr_pkg::WORD_W-1:0]   req_random_word,
   input  logic                          req_is_last,
   output logic                          rsp_found,
   output logic [ptwr_pkg::INDEX_W-1:0]  rsp_chosen_index,
   output logic signed [ptwr_pkg::PRIO_W-1:0]   rsp_chosen_priority
);
   import ptwr_pkg::*;

   localparam int IW = $clog2(MAX_CANDIDATES);
   localparam int CW = $clog2(MAX_CANDIDATES + 1);
   localparam int TW = WEIGHT_W + CW;

   logic signed [PRIO_W-1:0] prio_mem [MAX_CANDIDATES];
   logic [WEIGHT_W-1:0]      weight_mem [MAX_CANDIDATES];

   logic [CW-1:0]            count_ff, count_in;
   logic signed [PRIO_W-1:0] top_ff, top_in;
   logic [TW-1:0]            total_ff, total_in;
   logic [WORD_W-1:0]        word_ff, word_in;
   logic [TW-1:0]            rem_ff, rem_in;
   logic [TW-1:0]            roll_ff, roll_in;
   logic [IW-1:0]            walk_idx_ff, walk_idx_in;
   logic [IW-1:0]            chosen_ff, chosen_in;
   logic                     found_ff, found_in;
   logic signed [PRIO_W-1:0] rd_prio_ff;
   logic [WEIGHT_W-1:0]      rd_weight_ff;
   logic                     rsp_found_ff;
   logic [INDEX_W-1:0]       rsp_index_ff;
   logic signed [PRIO_W-1:0] rsp_prio_ff;

   logic                     store_we;
   logic [TW-1:0]            ew_req, ew_rd;
   logic [TW:0]              shifted;
   logic                     tier, fits, walk_end;

   assign store_we = cmd.load && req_is_candidate && (count_ff < CW'(MAX_CANDIDATES));
   assign ew_req   = (req_weight == '0) ? TW'(1) : TW'(req_weight);
   assign ew_rd    = (rd_weight_ff == '0) ? TW'(1) : TW'(rd_weight_ff);
   assign shifted  = {rem_ff, word_ff[WORD_W-1]};
   assign tier     = (rd_prio_ff == top_ff);
   assign fits     = (roll_ff <= ew_rd);
   assign walk_end = ((CW'(walk_idx_ff) + CW'(1)) == count_ff);

   assign status.list_empty = (count_ff == '0) && !req_is_candidate;
   assign status.walk_done  = (tier && fits) || walk_end;

   // tier tracking
   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      total_in = total_ff;
      if (store_we) begin
         count_in = count_ff + CW'(1);
         priority if ((count_ff == '0) || (req_priority > top_ff)) begin
            top_in   = req_priority;
            total_in = ew_req;
         end else if (req_priority == top_ff) begin
            total_in = total_ff + ew_req;
         end else begin
            total_in = total_ff;
         end
      end
      if (cmd.publish) begin
         count_in = '0;
         top_in   = '0;
         total_in = '0;
      end
   end

   // modulo, roll and walk
   always_comb begin
      word_in     = word_ff;
      rem_in      = rem_ff;
      roll_in     = roll_ff;
      walk_idx_in = walk_idx_ff;
      chosen_in   = chosen_ff;
      found_in    = found_ff;
      if (cmd.load && req_is_last) begin
         word_in  = req_random_word;
         rem_in   = '0;
         found_in = !status.list_empty;
      end
      if (cmd.div_step) begin
         word_in = word_ff << 1;
         if (shifted >= (TW + 1)'(total_ff)) begin
            rem_in = TW'(shifted - (TW + 1)'(total_ff));
         end else begin
            rem_in = shifted[TW-1:0];
         end
         if (cmd.div_last) begin
            roll_in     = rem_in + TW'(1);
            walk_idx_in = '0;
         end
      end
      if (cmd.test) begin
         walk_idx_in = walk_idx_ff + IW'(1);
         if (tier) begin
            chosen_in = walk_idx_ff;
            if (!fits) begin
               roll_in = roll_ff - ew_rd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         prio_mem[count_ff[IW-1:0]]   <= req_priority;
         weight_mem[count_ff[IW-1:0]] <= req_weight;
      end
      rd_prio_ff   <= prio_mem[walk_idx_ff];
      rd_weight_ff <= weight_mem[walk_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         top_ff   <= '0;
         total_ff <= '0;
      end else begin
         count_ff <= count_in;
         top_ff   <= top_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rem_ff      <= rem_in;
      roll_ff     <= roll_in;
      walk_idx_ff <= walk_idx_in;
      chosen_ff   <= chosen_in;
      found_ff    <= found_in;
      if (cmd.publish) begin
         rsp_found_ff <= found_ff;
         rsp_index_ff <= found_ff ? INDEX_W'(chosen_ff) : '0;
         rsp_prio_ff  <= found_ff ? top_ff : '0;
      end
   end

   assign rsp_found           = rsp_found_ff;
   assign rsp_chosen_index    = rsp_index_ff;
   assign rsp_chosen_priority = rsp_prio_ff;

`ifndef SYNTHESIS
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (total_ff != '0))
      else $error("stored candidates but empty tier total");

   a_roll_positive: assert property (@(posedge clock) disable iff (reset)
      cmd.test |-> (roll_ff != '0))
      else $error("roll dropped to zero during walk");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.test |-> (CW'(walk_idx_ff) < count_ff))
      else $error("walk index beyond stored candidates");
`endif

endmodule

[rtl/priority_tier_weighted_random_pick_unit.sv]
// ----------------------------------------------------------------------------
// priority_tier_weighted_random_pick_unit
// Weighted random pick among the highest-priority candidates of a list.
// ----------------------------------------------------------------------------
// Usage:
//   A list arrives on the req_ stream, one request per candidate, tuser set
//   when the request carries a candidate. tlast closes the list; the random
//   word of that request picks a candidate of the top priority tier with
//   probability proportional to its weight (zero weight counts as one).
//   Each closed list gives one response: tuser is the found flag, tdata the
//   load-order index and the priority of the chosen candidate (zeros when
//   the list held no candidate).
//   Throughput: one request per cycle while a list loads. After the closing
//   request the block runs the bit-serial modulo of the random word, then
//   walks the stored candidates in load order, each visit being one store
//   read and one compare, and then loads the response register; an empty
//   list goes straight to loading the response register.
//   req_tready is low from the closing request until the response register
//   is loaded. A stalled response holds; the next list may load meanwhile,
//   and its result waits until the held response is taken.
//   Reset clears the list state and drops rsp_tvalid; no clearing pass.
// ----------------------------------------------------------------------------
module priority_tier_weighted_random_pick_unit #(
   parameter int MAX_CANDIDATES = ptwr_pkg::MAX_CANDIDATES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // priority[31:0], weight[51:32], random_word[83:52], zero pad
   input  logic [ptwr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // is_candidate
   input  logic                              req_tuser,
   // is_last
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // chosen_index[5:0], chosen_priority[37:6], zero pad
   output logic [ptwr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found
   output logic                              rsp_tuser
);
   import ptwr_pkg::*;

   ptwr_cmd_type             cmd;
   ptwr_status_type          status;
   logic signed [PRIO_W-1:0] req_priority;
   logic [WEIGHT_W-1:0]      req_weight;
   logic [WORD_W-1:0]        req_random_word;
   logic [INDEX_W-1:0]       rsp_chosen_index;
   logic signed [PRIO_W-1:0] rsp_chosen_priority;

   assign req_priority    = req_tdata[PRIO_W-1:0];
   assign req_weight      = req_tdata[PRIO_W+WEIGHT_W-1:PRIO_W];
   assign req_random_word = req_tdata[PRIO_W+WEIGHT_W+WORD_W-1:PRIO_W+WEIGHT_W];

   assign rsp_tdata = {(RSP_DATA_W - INDEX_W - PRIO_W)'(0), rsp_chosen_priority,
                       rsp_chosen_index};

   ptwr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ptwr_dp #(
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_is_candidate    (req_tuser),
      .req_priority        (req_priority),
      .req_weight          (req_weight),
      .req_random_word     (req_random_word),
      .req_is_last         (req_tlast),
      .rsp_found           (rsp_tuser),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_chosen_priority (rsp_chosen_priority)
   );

endmodule

[test/ptwr_pick_checker.sv]
// ----------------------------------------------------------------------------
// ptwr_pick_checker
// Watches the request and response streams of the priority tier weighted
// random pick unit, predicts the pick of every closed list and compares each
// response field by field against the oldest predicted pick.
// ----------------------------------------------------------------------------
module ptwr_pick_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // priority[31:0], weight[51:32], random_word[83:52], zero pad
   input  logic [ptwr_pkg::REQ_DATA_W-1:0] req_tdata,
   // is_candidate
   input  logic                            req_tuser,
   // is_last
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // chosen_index[5:0], chosen_priority[37:6], zero pad
   input  logic [ptwr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found
   input  logic                            rsp_tuser,
   output int                              failures,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import ptwr_pkg::*;

   localparam int STORE_DEPTH = MAX_CANDIDATES_DEF;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] index;
      logic [PRIO_W-1:0]  prio;
   } pick_type;

   pick_type                  expected_picks[$];
   logic signed [PRIO_W-1:0]  prio_store [STORE_DEPTH];
   logic [WEIGHT_W-1:0]       weight_store [STORE_DEPTH];
   int                        loaded;
   logic signed [PRIO_W-1:0]  top_prio;
   longint unsigned           tier_sum;
   int                        fail_count = 0;

   task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t ns: pick mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task predict_pick(input logic [REQ_DATA_W-1:0] data, input logic cand, input logic closing);
      logic signed [PRIO_W-1:0] p;
      logic [WEIGHT_W-1:0]      w;
      logic [WORD_W-1:0]        word;
      longint unsigned          ew;
      longint unsigned          total;
      longint unsigned          roll;
      int                       chosen;
      int                       i;
      logic                     fitted;
      pick_type                 want;
      p    = data[PRIO_W-1:0];
      w    = data[PRIO_W+WEIGHT_W-1:PRIO_W];
      word = data[PRIO_W+WEIGHT_W+WORD_W-1:PRIO_W+WEIGHT_W];
      // candidates past a full store are dropped entirely
      if (cand && loaded < STORE_DEPTH) begin
         ew = (w == '0) ? 64'd1 : 64'(w);
         prio_store[loaded]   = p;
         weight_store[loaded] = w;
         if (loaded == 0 || p > top_prio) begin
            top_prio = p;
            tier_sum = ew;
         end else if (p == top_prio) begin
            tier_sum += ew;
         end
         loaded++;
      end
      if (closing) begin
         want = '0;
         if (loaded != 0) begin
            total  = (tier_sum == 64'd0) ? 64'd1 : tier_sum;
            roll   = (64'(word) % total) + 64'd1;
            chosen = 0;
            fitted = 1'b0;
            i      = 0;
            // walk the tier in load order until the roll fits
            while (i < loaded && !fitted) begin
               if (prio_store[i] == top_prio) begin
                  ew     = (weight_store[i] == '0) ? 64'd1 : 64'(weight_store[i]);
                  chosen = i;
                  if (roll <= ew) fitted = 1'b1;
                  else roll -= ew;
               end
               i++;
            end
            want.found = 1'b1;
            want.index = chosen[INDEX_W-1:0];
            want.prio  = prio_store[chosen];
         end
         expected_picks = {expected_picks, want};
         loaded   = 0;
         top_prio = '0;
         tier_sum = 0;
      end
   endtask

   task check_pick();
      pick_type got;
      pick_type want;
      got.found = rsp_tuser;
      got.index = rsp_tdata[INDEX_W-1:0];
      got.prio  = rsp_tdata[INDEX_W+PRIO_W-1:INDEX_W];
      if (expected_picks.size() == 0) begin
         report_mismatch("response with no list closed", 64'(got), 64'd0);
      end else begin
         want = expected_picks.pop_front();
         if (got.found !== want.found)
            report_mismatch("found", 64'(got.found), 64'(want.found));
         if (got.index !== want.index)
            report_mismatch("chosen_index", 64'(got.index), 64'(want.index));
         if (got.prio !== want.prio)
            report_mismatch("chosen_priority", 64'(got.prio), 64'(want.prio));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         loaded   = 0;
         top_prio = '0;
         tier_sum = 0;
         expected_picks.delete();
      end else begin
         // a response always belongs to an earlier list, so check before predicting
         if (rsp_tvalid && rsp_tready) check_pick();
         if (req_tvalid && req_tready) predict_pick(req_tdata, req_tuser, req_tlast);
      end
      failures <= fail_count;
      pending  <= expected_picks.size();
   end

endmodule

[test/priority_tier_weighted_random_pick_unit_tb.sv]
// ----------------------------------------------------------------------------
// priority_tier_weighted_random_pick_unit_tb
// Drives candidate lists into the pick unit: a directed set covering empty
// lists, extreme priorities and weights, zero weights, interleaved empty
// requests and separate terminators, then random lists with ties, full
// stores and random stalls on both streams. The checker predicts each pick.
// ----------------------------------------------------------------------------
module priority_tier_weighted_random_pick_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptwr_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int LONG_HOLD      = 600;
   localparam int DRAIN_CYCLES   = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // priority[31:0], weight[51:32], random_word[83:52], zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   // is_candidate
   logic                  req_tuser;
   // is_last
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // chosen_index[5:0], chosen_priority[37:6], zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // found
   logic                  rsp_tuser;
   int                    failures;
   int                    pending;
   logic                  burst;

   priority_tier_weighted_random_pick_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ptwr_pick_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [PRIO_W-1:0] rand_prio();
      unique case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2, 3:    return $urandom;
         // narrow range so that tiers share a priority
         default: return $urandom_range(0, 3) - 1;
      endcase
   endfunction

   function automatic logic [WEIGHT_W-1:0] rand_weight();
      unique case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return WEIGHT_W'($urandom_range(0, 3));
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      unique case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task send_request(input logic cand, input logic [PRIO_W-1:0] p,
                     input logic [WEIGHT_W-1:0] w, input logic [WORD_W-1:0] word,
                     input logic closing);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-PRIO_W-WEIGHT_W-WORD_W){1'b0}}, word, w, p};
      req_tuser  <= cand;
      req_tlast  <= closing;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // response side: random stalls, quiet stretches and two long hold-offs
   initial begin
      int   stall;
      int   taken;
      logic quiet;
      taken = 0;
      quiet = 1'b0;
      rsp_tready <= 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) quiet = ~quiet;
         if (taken == 25 || taken == 120) stall = LONG_HOLD;
         else stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("priority_tier_weighted_random_pick_unit verification failed");
      $finish;
   end

   initial begin
      int   sent;
      int   len;
      int   kind;
      logic trailing;
      logic closing;
      sent  = 0;
      burst = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list
      send_request(1'b0, 32'h7fff_ffff, '1, '1, 1'b1);
      // single candidate, zero weight, all-ones word
      send_request(1'b1, 32'h7fff_ffff, '0, '1, 1'b1);
      // two minimum priorities at full weight, zero word
      send_request(1'b1, 32'h8000_0000, '1, '0, 1'b0);
      send_request(1'b1, 32'h8000_0000, '1, '0, 1'b1);
      // mixed tier with an empty request inside and a separate terminator
      send_request(1'b1, 32'hffff_ffff, 20'd5, '0, 1'b0);
      send_request(1'b1, 32'd7, 20'd3, '0, 1'b0);
      send_request(1'b1, 32'd7, 20'd0, '0, 1'b0);
      send_request(1'b0, 32'd7, '1, '1, 1'b0);
      send_request(1'b1, 32'd7, 20'd4, '0, 1'b0);
      send_request(1'b0, '0, '0, 32'd3, 1'b1);
      // rising priorities replace the tier each time
      burst = 1'b1;
      send_request(1'b1, 32'h8000_0000, '1, '0, 1'b0);
      send_request(1'b1, 32'd0, '1, '0, 1'b0);
      send_request(1'b1, 32'h7fff_ffff, 20'd1, '1, 1'b1);
      // lower priority after the top does not join the tier
      send_request(1'b1, 32'd2, 20'd9, '0, 1'b0);
      send_request(1'b1, 32'd1, '1, '0, 1'b0);
      send_request(1'b1, 32'd2, 20'd0, 32'd9, 1'b1);
      // full-weight tier of the highest priority
      burst = 1'b0;
      send_request(1'b1, 32'h7fff_ffff, '1, '0, 1'b0);
      send_request(1'b1, 32'h7fff_ffff, '1, '0, 1'b0);
      send_request(1'b1, 32'h7fff_ffff, '1, '1, 1'b1);
      // empty list with a stray empty request first
      send_request(1'b0, '1, '1, '1, 1'b0);
      send_request(1'b0, '0, '0, '0, 1'b1);

      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 3) == 0);
         kind  = $urandom_range(0, 39);
         if (kind < 2) begin
            send_request(1'b0, rand_prio(), rand_weight(), rand_word(), 1'b1);
            sent++;
         end else if (kind < 4) begin
            // stray empty request, ignored by the block
            send_request(1'b0, rand_prio(), rand_weight(), $urandom, 1'b0);
            sent++;
         end else begin
            // one draw in forty makes a long list that may overflow the candidate store
            len      = (kind == 4) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            trailing = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_request(1'b0, rand_prio(), rand_weight(), $urandom, 1'b0);
                  sent++;
               end
               closing = (k == len - 1) && !trailing;
               send_request(1'b1, rand_prio(), rand_weight(),
                            closing ? rand_word() : $urandom, closing);
               sent++;
            end
            if (trailing) begin
               send_request(1'b0, rand_prio(), rand_weight(), rand_word(), 1'b1);
               sent++;
            end
         end
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("priority_tier_weighted_random_pick_unit verification clean");
      end else begin
         $display("priority_tier_weighted_random_pick_unit verification failed");
      end
      $finish;
   end

endmodule
